@@ sv/rrtne_pkg.sv @@
// Shared types, constants and helpers for the tree extend engine.
package rrtne_pkg;

    localparam int CW            = 16;
    localparam int STEPW         = 8;
    localparam int THRW          = 12;
    localparam int PARW          = 10;
    localparam int CNTW          = 11;
    localparam int REQW          = 2;
    localparam int CFG_IDXW      = 3;
    localparam int CFG_DW        = 16;
    localparam int SW            = 2 * CW + 2;
    localparam int RW            = CW + 1;

    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_FRAC_BITS = 4;

    localparam logic [CW-1:0]    RST_START_X = 16'd3200;
    localparam logic [CW-1:0]    RST_START_Y = 16'd3200;
    localparam logic [CW-1:0]    RST_GOAL_X  = 16'd0;
    localparam logic [CW-1:0]    RST_GOAL_Y  = 16'd0;
    localparam logic [STEPW-1:0] RST_STEP    = 8'd5;
    localparam logic [THRW-1:0]  RST_THR     = 12'd10;

    typedef enum logic [REQW-1:0] {
        REQ_EXTEND = 2'd0,
        REQ_COMMIT = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [CFG_IDXW-1:0] {
        CFG_START_X = 3'd0,
        CFG_START_Y = 3'd1,
        CFG_GOAL_X  = 3'd2,
        CFG_GOAL_Y  = 3'd3,
        CFG_STEP    = 3'd4,
        CFG_REACH   = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        RES_EXTEND,
        RES_COMMIT,
        RES_FULL,
        RES_EMPTY,
        RES_CLEAR,
        RES_NONE
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WSQRT,
        S_DIVX,
        S_DIVY,
        S_GSQRT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load_req;
        logic scan_start;
        logic scan_run;
        logic sqrt_run;
        logic lim_load;
        logic div_load_x;
        logic div_load_y;
        logic div_run;
        logic cand_x_load;
        logic cand_y_load;
        logic cand_node;
        logic commit_write;
        logic clear_tree;
        logic res_load;
        t_res res_kind;
    } t_cmd;

    typedef struct packed {
        logic held_valid;
        logic table_full;
        logic win;
        logic scan_done;
        logic sqrt_done;
        logic div_done;
        logic n_zero;
    } t_sts;

    function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ sv/rrt_nearest_extend_engine_top.sv @@
// Top level of the tree nearest-node and extend engine.
//
// Input channel: i_in_valid / o_in_ready carry one request beat (type, sample x/y).
// Output channel: o_out_valid / i_out_ready carry one result beat per request.
// Config: i_cfg_wr_en writes i_cfg_wdata into register i_cfg_index;
// write only while the engine is idle. A new root takes effect at the next clear.
// Sequence: clear, a refused commit and the unused type go straight to emit.
// Commit runs the 17-step square root for the goal distance. Extend scans the
// nodes one per cycle through a RAM read and square stage, pausing to run the
// shared square root unit each time a nearer node is found (the scan resumes
// after the new best), then runs two restoring divides on an NW-bit numerator,
// NW = 8 + FRAC_BITS + 16, and emits; the divides are skipped when the sample
// sits on the nearest node.
// One request is in flight at a time; ready rises when the result is registered.
// The result register lets the next request be taken while a result waits; if
// the receiver stalls, the following result waits in its last state.
// Reset: the tree holds only the root (3200, 3200), nothing held, registers at
// their defaults. Node table contents need no clearing.
module rrt_nearest_extend_engine_top #(
    parameter int MAX_NODES = rrtne_pkg::DEF_MAX_NODES,
    parameter int FRAC_BITS = rrtne_pkg::DEF_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [rrtne_pkg::CFG_IDXW-1:0] i_cfg_index,
    input  logic [rrtne_pkg::CFG_DW-1:0]   i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [rrtne_pkg::REQW-1:0]     i_req_type,
    input  logic [rrtne_pkg::CW-1:0]       i_sample_x,
    input  logic [rrtne_pkg::CW-1:0]       i_sample_y,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [rrtne_pkg::CW-1:0]       o_cand_x,
    output logic [rrtne_pkg::CW-1:0]       o_cand_y,
    output logic [rrtne_pkg::PARW-1:0]     o_parent_index,
    output logic                           o_goal_reached,
    output logic [1:0]                     o_status,
    output logic [rrtne_pkg::CNTW-1:0]     o_node_count
);
    import rrtne_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rrtne_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    rrtne_dpath #(
        .MAX_NODES (MAX_NODES),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_sample_x     (i_sample_x),
        .i_sample_y     (i_sample_y),
        .o_cand_x       (o_cand_x),
        .o_cand_y       (o_cand_y),
        .o_parent_index (o_parent_index),
        .o_goal_reached (o_goal_reached),
        .o_status       (o_status),
        .o_node_count   (o_node_count)
    );

endmodule

@@ sv/rrtne_ram.sv @@
// Generic single write port RAM with registered read.
module rrtne_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ sv/rrtne_ctrl.sv @@
// Request sequencer: decodes beats and steps the datapath through scan, root and divide.
module rrtne_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic [rrtne_pkg::REQW-1:0] i_req_type,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output rrtne_pkg::t_cmd        o_cmd,
    input  rrtne_pkg::t_sts        i_sts
);
    import rrtne_pkg::*;

    t_state r_state, n_state;
    t_res   r_kind, n_kind;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= RES_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_kind         = r_kind;
        n_out_valid    = r_out_valid && !i_out_ready;
        o_cmd          = '0;
        o_cmd.res_kind = r_kind;
        o_in_ready     = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    case (t_req'(i_req_type))
                        REQ_EXTEND: begin
                            o_cmd.scan_start = 1'b1;
                            n_kind           = RES_EXTEND;
                            n_state          = S_SCAN;
                        end
                        REQ_COMMIT: begin
                            if (!i_sts.held_valid) begin
                                n_kind  = RES_EMPTY;
                                n_state = S_EMIT;
                            end else if (i_sts.table_full) begin
                                n_kind  = RES_FULL;
                                n_state = S_EMIT;
                            end else begin
                                o_cmd.commit_write = 1'b1;
                                n_kind             = RES_COMMIT;
                                n_state            = S_GSQRT;
                            end
                        end
                        REQ_CLEAR: begin
                            o_cmd.clear_tree = 1'b1;
                            n_kind           = RES_CLEAR;
                            n_state          = S_EMIT;
                        end
                        default: begin
                            n_kind  = RES_NONE;
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.win) begin
                    n_state = S_WSQRT;
                end else if (i_sts.scan_done) begin
                    if (i_sts.n_zero) begin
                        o_cmd.cand_node = 1'b1;
                        n_state         = S_EMIT;
                    end else begin
                        o_cmd.div_load_x = 1'b1;
                        n_state          = S_DIVX;
                    end
                end
            end
            S_WSQRT: begin
                o_cmd.sqrt_run = 1'b1;
                if (i_sts.sqrt_done) begin
                    o_cmd.lim_load = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_DIVX: begin
                o_cmd.div_run = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.cand_x_load = 1'b1;
                    o_cmd.div_load_y  = 1'b1;
                    n_state           = S_DIVY;
                end
            end
            S_DIVY: begin
                o_cmd.div_run = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.cand_y_load = 1'b1;
                    n_state           = S_EMIT;
                end
            end
            S_GSQRT: begin
                o_cmd.sqrt_run = 1'b1;
                if (i_sts.sqrt_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ sv/rrtne_dpath.sv @@
// Datapath: node table, nearest scan pipeline, square root and divide units, result register.
module rrtne_dpath #(
    parameter int MAX_NODES = rrtne_pkg::DEF_MAX_NODES,
    parameter int FRAC_BITS = rrtne_pkg::DEF_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rrtne_pkg::t_cmd                i_cmd,
    output rrtne_pkg::t_sts                o_sts,
    input  logic                           i_cfg_wr_en,
    input  logic [rrtne_pkg::CFG_IDXW-1:0] i_cfg_index,
    input  logic [rrtne_pkg::CFG_DW-1:0]   i_cfg_wdata,
    input  logic [rrtne_pkg::CW-1:0]       i_sample_x,
    input  logic [rrtne_pkg::CW-1:0]       i_sample_y,
    output logic [rrtne_pkg::CW-1:0]       o_cand_x,
    output logic [rrtne_pkg::CW-1:0]       o_cand_y,
    output logic [rrtne_pkg::PARW-1:0]     o_parent_index,
    output logic                           o_goal_reached,
    output logic [1:0]                     o_status,
    output logic [rrtne_pkg::CNTW-1:0]     o_node_count
);
    import rrtne_pkg::*;

    localparam int AW    = $clog2(MAX_NODES);
    localparam int CTW   = $clog2(MAX_NODES + 1);
    localparam int NW    = STEPW + FRAC_BITS + CW;
    localparam int REMW  = RW + 2;
    localparam int SQCW  = $clog2(RW + 1);
    localparam int DVCW  = $clog2(NW + 1);
    localparam int LIMW  = SW + 1;
    localparam logic [LIMW-1:0] LIM_INF = LIMW'(1) << SW;
    localparam logic [NW:0]     CMAX    = (NW+1)'({CW{1'b1}});

    // configuration
    logic [CW-1:0]    r_start_x, r_start_y, r_goal_x, r_goal_y;
    logic [STEPW-1:0] r_step;
    logic [THRW-1:0]  r_thr;

    // tree state
    logic [CW-1:0]    r_root_x, r_root_y;
    logic [CTW-1:0]   r_count;
    logic [CW-1:0]    r_held_x, r_held_y;
    logic [AW-1:0]    r_held_par;
    logic             r_held_v;

    logic [CW-1:0]    r_smp_x, r_smp_y;

    // scan pipeline
    logic [CTW-1:0]   r_rd_idx;
    logic             r_s1_v, r_s2_v;
    logic [AW-1:0]    r_s1_idx, r_s2_idx;
    logic [2*CW-1:0]  r_s2_sqx, r_s2_sqy;
    logic [CW-1:0]    r_s2_nx, r_s2_ny;
    logic [LIMW-1:0]  r_best_lim;
    logic [AW-1:0]    r_best_idx;
    logic [CW-1:0]    r_best_x, r_best_y;
    logic [RW-1:0]    r_best_n;

    // square root unit
    logic [SW-1:0]    r_sq_rad;
    logic [REMW-1:0]  r_sq_rem;
    logic [RW-1:0]    r_sq_root;
    logic [SQCW-1:0]  r_sq_cnt;

    // divider
    logic [NW-1:0]    r_dv_num;
    logic [RW-1:0]    r_dv_rem;
    logic [DVCW-1:0]  r_dv_cnt;
    logic             r_dv_axis_y;

    logic [CW-1:0]    r_cand_x, r_cand_y;

    logic [2*CW-1:0]  ram_rdata;
    logic             rd_issue;
    logic [CW-1:0]    s1_nx, s1_ny, s1_dx, s1_dy;
    logic [SW-1:0]    s2_sum;
    logic             win;
    logic [CW-1:0]    g_dx, g_dy;
    logic [SW-1:0]    g_sum;
    logic [REMW-1:0]  sq_remx, sq_trial;
    logic [RW:0]      dv_remx;
    logic [RW-1:0]    root_mask;
    logic [NW-1:0]    dv_prod;
    logic [STEPW+FRAC_BITS-1:0] step_f;
    logic [CW-1:0]    dv_mag;
    logic [CW-1:0]    dv_node, dv_smp, cand_sat;
    logic [NW:0]      up_sum;
    logic             goal_hit;

    rrtne_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_NODES)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit_write),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({r_held_x, r_held_y}),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_issue = (r_rd_idx < r_count);
    assign s1_nx    = (r_s1_idx == '0) ? r_root_x : ram_rdata[2*CW-1:CW];
    assign s1_ny    = (r_s1_idx == '0) ? r_root_y : ram_rdata[CW-1:0];
    assign s1_dx    = abs_diff(r_smp_x, s1_nx);
    assign s1_dy    = abs_diff(r_smp_y, s1_ny);
    assign s2_sum   = SW'(r_s2_sqx) + SW'(r_s2_sqy);
    assign win      = r_s2_v && (LIMW'(s2_sum) < r_best_lim);

    assign g_dx     = abs_diff(r_held_x, r_goal_x);
    assign g_dy     = abs_diff(r_held_y, r_goal_y);
    assign g_sum    = SW'(g_dx) * SW'(g_dx) + SW'(g_dy) * SW'(g_dy);

    assign sq_remx  = {r_sq_rem[REMW-3:0], r_sq_rad[SW-1 -: 2]};
    assign sq_trial = {r_sq_root, 2'b01};
    assign root_mask = (r_sq_root >> FRAC_BITS) << FRAC_BITS;

    assign dv_remx  = {r_dv_rem, r_dv_num[NW-1]};
    assign step_f   = (STEPW+FRAC_BITS)'(r_step) << FRAC_BITS;
    assign dv_mag   = i_cmd.div_load_y ? abs_diff(r_smp_y, r_best_y)
                                       : abs_diff(r_smp_x, r_best_x);
    assign dv_prod  = NW'(step_f) * NW'(dv_mag);

    // clamp node plus or minus the quotient into the coordinate range
    assign dv_node  = r_dv_axis_y ? r_best_y : r_best_x;
    assign dv_smp   = r_dv_axis_y ? r_smp_y : r_smp_x;
    assign up_sum   = (NW+1)'(dv_node) + (NW+1)'(r_dv_num);
    always_comb begin
        if (dv_smp >= dv_node) begin
            cand_sat = (up_sum > CMAX) ? {CW{1'b1}} : up_sum[CW-1:0];
        end else if (r_dv_num > NW'(dv_node)) begin
            cand_sat = '0;
        end else begin
            cand_sat = dv_node - r_dv_num[CW-1:0];
        end
    end

    assign goal_hit = (r_sq_root >> FRAC_BITS) < RW'(r_thr);

    assign o_sts.held_valid = r_held_v;
    assign o_sts.table_full = (r_count >= CTW'(MAX_NODES));
    assign o_sts.win        = win;
    assign o_sts.scan_done  = !rd_issue && !r_s1_v && !r_s2_v;
    assign o_sts.sqrt_done  = (r_sq_cnt == '0);
    assign o_sts.div_done   = (r_dv_cnt == '0);
    assign o_sts.n_zero     = (r_best_n == '0);

    // configuration and tree state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x  <= RST_START_X;
            r_start_y  <= RST_START_Y;
            r_goal_x   <= RST_GOAL_X;
            r_goal_y   <= RST_GOAL_Y;
            r_step     <= RST_STEP;
            r_thr      <= RST_THR;
            r_root_x   <= RST_START_X;
            r_root_y   <= RST_START_Y;
            r_count    <= CTW'(1);
            r_held_x   <= '0;
            r_held_y   <= '0;
            r_held_par <= '0;
            r_held_v   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_START_X: r_start_x <= i_cfg_wdata;
                    CFG_START_Y: r_start_y <= i_cfg_wdata;
                    CFG_GOAL_X:  r_goal_x  <= i_cfg_wdata;
                    CFG_GOAL_Y:  r_goal_y  <= i_cfg_wdata;
                    CFG_STEP:    r_step    <= i_cfg_wdata[STEPW-1:0];
                    CFG_REACH:   r_thr     <= i_cfg_wdata[THRW-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clear_tree) begin
                r_root_x <= r_start_x;
                r_root_y <= r_start_y;
                r_count  <= CTW'(1);
                r_held_v <= 1'b0;
            end
            if (i_cmd.commit_write) begin
                r_count  <= r_count + CTW'(1);
                r_held_v <= 1'b0;
            end
            if (i_cmd.res_load && i_cmd.res_kind == RES_EXTEND) begin
                r_held_x   <= r_cand_x;
                r_held_y   <= r_cand_y;
                r_held_par <= r_best_idx;
                r_held_v   <= 1'b1;
            end
        end
    end

    // scan control and unit counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_sq_cnt <= '0;
            r_dv_cnt <= '0;
        end else begin
            if (i_cmd.scan_start) begin
                r_rd_idx <= '0;
                r_s1_v   <= 1'b0;
                r_s2_v   <= 1'b0;
            end else if (i_cmd.scan_run) begin
                if (win) begin
                    r_rd_idx <= CTW'(r_s2_idx) + CTW'(1);
                    r_s1_v   <= 1'b0;
                    r_s2_v   <= 1'b0;
                end else begin
                    r_rd_idx <= r_rd_idx + CTW'(rd_issue);
                    r_s1_v   <= rd_issue;
                    r_s2_v   <= r_s1_v;
                end
            end
            if ((i_cmd.scan_run && win) || i_cmd.commit_write) begin
                r_sq_cnt <= SQCW'(RW);
            end else if (i_cmd.sqrt_run && r_sq_cnt != '0) begin
                r_sq_cnt <= r_sq_cnt - SQCW'(1);
            end
            if (i_cmd.div_load_x || i_cmd.div_load_y) begin
                r_dv_cnt <= DVCW'(NW);
            end else if (i_cmd.div_run && r_dv_cnt != '0) begin
                r_dv_cnt <= r_dv_cnt - DVCW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_smp_x <= i_sample_x;
            r_smp_y <= i_sample_y;
        end
        if (i_cmd.scan_start) begin
            r_best_lim <= LIM_INF;
        end
        if (i_cmd.scan_run) begin
            r_s1_idx <= r_rd_idx[AW-1:0];
            r_s2_idx <= r_s1_idx;
            r_s2_sqx <= (2*CW)'(s1_dx) * (2*CW)'(s1_dx);
            r_s2_sqy <= (2*CW)'(s1_dy) * (2*CW)'(s1_dy);
            r_s2_nx  <= s1_nx;
            r_s2_ny  <= s1_ny;
            if (win) begin
                r_best_idx <= r_s2_idx;
                r_best_x   <= r_s2_nx;
                r_best_y   <= r_s2_ny;
            end
        end
        if (i_cmd.lim_load) begin
            r_best_lim <= LIMW'(root_mask) * LIMW'(root_mask);
            r_best_n   <= r_sq_root;
        end

        if ((i_cmd.scan_run && win) || i_cmd.commit_write) begin
            r_sq_rad  <= i_cmd.commit_write ? g_sum : s2_sum;
            r_sq_rem  <= '0;
            r_sq_root <= '0;
        end else if (i_cmd.sqrt_run && r_sq_cnt != '0) begin
            r_sq_rad <= r_sq_rad << 2;
            if (sq_remx >= sq_trial) begin
                r_sq_rem  <= sq_remx - sq_trial;
                r_sq_root <= {r_sq_root[RW-2:0], 1'b1};
            end else begin
                r_sq_rem  <= sq_remx;
                r_sq_root <= {r_sq_root[RW-2:0], 1'b0};
            end
        end

        if (i_cmd.div_load_x || i_cmd.div_load_y) begin
            r_dv_num    <= dv_prod;
            r_dv_rem    <= '0;
            r_dv_axis_y <= i_cmd.div_load_y;
        end else if (i_cmd.div_run && r_dv_cnt != '0) begin
            if (dv_remx >= {1'b0, r_best_n}) begin
                r_dv_rem <= RW'(dv_remx - {1'b0, r_best_n});
                r_dv_num <= {r_dv_num[NW-2:0], 1'b1};
            end else begin
                r_dv_rem <= dv_remx[RW-1:0];
                r_dv_num <= {r_dv_num[NW-2:0], 1'b0};
            end
        end

        if (i_cmd.cand_node) begin
            r_cand_x <= r_best_x;
            r_cand_y <= r_best_y;
        end
        if (i_cmd.cand_x_load) begin
            r_cand_x <= cand_sat;
        end
        if (i_cmd.cand_y_load) begin
            r_cand_y <= cand_sat;
        end

        if (i_cmd.res_load) begin
            o_node_count <= CNTW'(r_count);
            case (i_cmd.res_kind)
                RES_EXTEND: begin
                    o_cand_x       <= r_cand_x;
                    o_cand_y       <= r_cand_y;
                    o_parent_index <= PARW'(r_best_idx);
                    o_goal_reached <= 1'b0;
                    o_status       <= ST_OK;
                end
                RES_COMMIT: begin
                    o_cand_x       <= r_held_x;
                    o_cand_y       <= r_held_y;
                    o_parent_index <= PARW'(r_held_par);
                    o_goal_reached <= goal_hit;
                    o_status       <= ST_OK;
                end
                RES_FULL: begin
                    o_cand_x       <= r_held_x;
                    o_cand_y       <= r_held_y;
                    o_parent_index <= PARW'(r_held_par);
                    o_goal_reached <= 1'b0;
                    o_status       <= ST_FULL;
                end
                RES_EMPTY: begin
                    o_cand_x       <= '0;
                    o_cand_y       <= '0;
                    o_parent_index <= '0;
                    o_goal_reached <= 1'b0;
                    o_status       <= ST_EMPTY;
                end
                RES_CLEAR: begin
                    o_cand_x       <= r_root_x;
                    o_cand_y       <= r_root_y;
                    o_parent_index <= '0;
                    o_goal_reached <= 1'b0;
                    o_status       <= ST_OK;
                end
                default: begin
                    o_cand_x       <= '0;
                    o_cand_y       <= '0;
                    o_parent_index <= '0;
                    o_goal_reached <= 1'b0;
                    o_status       <= ST_OK;
                end
            endcase
        end
    end

endmodule

@@ verif/rrt_nearest_extend_engine_top_tb.sv @@
// Self-checking testbench for the tree nearest-node and extend engine.
`timescale 1ns / 100ps

module rrt_nearest_extend_engine_top_tb;
    import rrtne_pkg::*;

    localparam int MAXN       = DEF_MAX_NODES;
    localparam int FB         = DEF_FRAC_BITS;
    localparam int CYCLE_CAP  = 8000000;
    localparam int RAND_ITEMS = 540;

    typedef struct {
        t_req        req;
        logic [15:0] sx;
        logic [15:0] sy;
    } t_request;

    typedef struct {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [9:0]  par;
        logic        reached;
        t_status     st;
        logic [10:0] cnt;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_req_type;
    logic [15:0] i_sample_x;
    logic [15:0] i_sample_y;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_cand_x;
    logic [15:0] o_cand_y;
    logic [9:0]  o_parent_index;
    logic        o_goal_reached;
    logic [1:0]  o_status;
    logic [10:0] o_node_count;

    rrt_nearest_extend_engine_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_req_type(i_req_type),
        .i_sample_x(i_sample_x), .i_sample_y(i_sample_y),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_cand_x(o_cand_x), .o_cand_y(o_cand_y), .o_parent_index(o_parent_index),
        .o_goal_reached(o_goal_reached), .o_status(o_status), .o_node_count(o_node_count)
    );

    // tree model state
    logic [15:0] tree_x[MAXN];
    logic [15:0] tree_y[MAXN];
    int          tree_cnt;
    logic [15:0] cand_hx, cand_hy;
    logic [9:0]  cand_hpar;
    logic        cand_held;
    logic [15:0] root_x, root_y, goal_x, goal_y;
    logic [7:0]  step_len;
    logic [11:0] reach_thr;

    t_request request_q[$];
    t_outcome outcome_q[$];
    int       errors;
    int       n_results;
    int       n_full;
    int       n_reached;
    bit       quiet;
    bit       in_taken;
    bit       in_busy;
    int       in_gap;
    int       out_gap;
    longint   cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] dist_sq(input logic [15:0] ax, input logic [15:0] ay,
                                            input logic [15:0] bx, input logic [15:0] by);
        logic [63:0] dx, dy;
        dx = (ax > bx) ? 64'(ax - bx) : 64'(bx - ax);
        dy = (ay > by) ? 64'(ay - by) : 64'(by - ay);
        return dx * dx + dy * dy;
    endfunction

    function automatic logic [15:0] step_toward(input logic [15:0] from, input logic [15:0] to,
                                                input logic [63:0] n);
        logic [63:0] mag, off;
        longint      r;
        mag = (from > to) ? 64'(from - to) : 64'(to - from);
        off = ((64'(step_len) << FB) * mag) / n;
        if (to >= from) r = longint'(from) + longint'(off);
        else r = longint'(from) - longint'(off);
        if (r < 0) r = 0;
        if (r > 65535) r = 65535;
        return r[15:0];
    endfunction

    task automatic tree_request(input t_request rq);
        t_outcome    o;
        int          best;
        logic [63:0] bestd, d, n;
        o = '{16'd0, 16'd0, 10'd0, 1'b0, ST_OK, 11'd0};
        case (rq.req)
            REQ_EXTEND: begin
                best  = 0;
                bestd = int_sqrt(dist_sq(rq.sx, rq.sy, tree_x[0], tree_y[0])) >> FB;
                for (int i = 1; i < tree_cnt; i++) begin
                    d = int_sqrt(dist_sq(rq.sx, rq.sy, tree_x[i], tree_y[i])) >> FB;
                    if (d < bestd) begin
                        bestd = d;
                        best  = i;
                    end
                end
                n = int_sqrt(dist_sq(rq.sx, rq.sy, tree_x[best], tree_y[best]));
                if (n == 0) begin
                    o.cx = tree_x[best];
                    o.cy = tree_y[best];
                end else begin
                    o.cx = step_toward(tree_x[best], rq.sx, n);
                    o.cy = step_toward(tree_y[best], rq.sy, n);
                end
                o.par     = best[9:0];
                cand_hx   = o.cx;
                cand_hy   = o.cy;
                cand_hpar = o.par;
                cand_held = 1'b1;
            end
            REQ_COMMIT: begin
                if (!cand_held) begin
                    o.st = ST_EMPTY;
                end else if (tree_cnt >= MAXN) begin
                    o.st  = ST_FULL;
                    o.cx  = cand_hx;
                    o.cy  = cand_hy;
                    o.par = cand_hpar;
                end else begin
                    tree_x[tree_cnt] = cand_hx;
                    tree_y[tree_cnt] = cand_hy;
                    tree_cnt++;
                    cand_held = 1'b0;
                    o.cx  = cand_hx;
                    o.cy  = cand_hy;
                    o.par = cand_hpar;
                    o.reached = (int_sqrt(dist_sq(cand_hx, cand_hy, goal_x, goal_y)) >> FB)
                                < 64'(reach_thr);
                end
            end
            REQ_CLEAR: begin
                tree_x[0] = root_x;
                tree_y[0] = root_y;
                tree_cnt  = 1;
                cand_held = 1'b0;
                o.cx = root_x;
                o.cy = root_y;
            end
            default: ;
        endcase
        o.cnt = tree_cnt[10:0];
        outcome_q.insert(outcome_q.size(), o);
    endtask

    task automatic add(input t_req r, input logic [15:0] x, input logic [15:0] y);
        t_request rq;
        rq = '{r, x, y};
        request_q.insert(request_q.size(), rq);
    endtask

    task automatic wait_drained();
        wait (request_q.size() == 0 && outcome_q.size() == 0 && !in_busy);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_START_X: root_x    = val;
            CFG_START_Y: root_y    = val;
            CFG_GOAL_X:  goal_x    = val;
            CFG_GOAL_Y:  goal_y    = val;
            CFG_STEP:    step_len  = val[7:0];
            CFG_REACH:   reach_thr = val[11:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(input int count, input logic [15:0] cx, input logic [15:0] cy);
        int          r;
        int          since_clear;
        logic [15:0] x, y;
        since_clear = 0;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 2) == 0) begin
                x = 16'($urandom);
                y = 16'($urandom);
            end else begin
                x = cx + 16'($signed($urandom_range(0, 2047)) - 1024);
                y = cy + 16'($signed($urandom_range(0, 2047)) - 1024);
            end
            if (since_clear > 40) begin
                add(REQ_CLEAR, 16'($urandom), 16'($urandom));
                since_clear = 0;
            end else if (r < 70) begin
                add(REQ_EXTEND, x, y);
                add(REQ_COMMIT, 16'($urandom), 16'($urandom));
                if ($urandom_range(0, 9) == 0) add(REQ_COMMIT, x, y);
                since_clear++;
                k++;
            end else if (r < 78) begin
                add(REQ_COMMIT, x, y);
            end else if (r < 85) begin
                add(REQ_CLEAR, x, y);
                since_clear = 0;
            end else if (r < 90) begin
                add(REQ_NONE, x, y);
            end else begin
                add(REQ_EXTEND, x, y);
            end
        end
    endtask

    // input handshake, prediction and result check
    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n) begin
            cycles <= cycles + 1;
            if (i_in_valid && o_in_ready) begin
                tree_request('{t_req'(i_req_type), i_sample_x, i_sample_y});
                in_taken = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (outcome_q.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with nothing expected, actual %h %h %h %b %0d %0d",
                             $time, o_cand_x, o_cand_y, o_parent_index, o_goal_reached,
                             o_status, o_node_count);
                end else begin
                    e = outcome_q.pop_front();
                    if (e.st == ST_FULL) n_full++;
                    if (e.reached) n_reached++;
                    if (o_cand_x !== e.cx) begin
                        errors++;
                        $display("%0t: cand_x expected %h actual %h", $time, e.cx, o_cand_x);
                    end
                    if (o_cand_y !== e.cy) begin
                        errors++;
                        $display("%0t: cand_y expected %h actual %h", $time, e.cy, o_cand_y);
                    end
                    if (o_parent_index !== e.par) begin
                        errors++;
                        $display("%0t: parent_index expected %0d actual %0d",
                                 $time, e.par, o_parent_index);
                    end
                    if (o_goal_reached !== e.reached) begin
                        errors++;
                        $display("%0t: goal_reached expected %b actual %b",
                                 $time, e.reached, o_goal_reached);
                    end
                    if (o_status !== e.st) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time, e.st, o_status);
                    end
                    if (o_node_count !== e.cnt) begin
                        errors++;
                        $display("%0t: node_count expected %0d actual %0d",
                                 $time, e.cnt, o_node_count);
                    end
                end
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        t_request rq;
        if (i_rst_n) begin
            if (in_taken) begin
                in_taken = 1'b0;
                in_busy  = 1'b0;
            end
            if (!in_busy) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    if (!quiet && $urandom_range(0, 5) == 0) begin
                        in_gap = $urandom_range(0, 12);
                        i_in_valid <= 1'b0;
                    end else begin
                        rq = request_q.pop_front();
                        i_in_valid <= 1'b1;
                        i_req_type <= rq.req;
                        i_sample_x <= rq.sx;
                        i_sample_y <= rq.sy;
                        in_busy = 1'b1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_gap > 0) begin
                out_gap--;
                i_out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_gap = $urandom_range(0, 12);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_CAP) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_req_type  = '0;
        i_sample_x  = '0;
        i_sample_y  = '0;
        i_out_ready = 1'b0;
        errors = 0; n_results = 0; n_full = 0; n_reached = 0;
        quiet = 0; in_taken = 0; in_busy = 0; in_gap = 0; out_gap = 0; cycles = 0;
        root_x = RST_START_X; root_y = RST_START_Y;
        goal_x = RST_GOAL_X;  goal_y = RST_GOAL_Y;
        step_len = RST_STEP;  reach_thr = RST_THR;
        tree_x[0] = root_x; tree_y[0] = root_y; tree_cnt = 1;
        cand_hx = '0; cand_hy = '0; cand_hpar = '0; cand_held = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed
        add(REQ_COMMIT, 16'hffff, 16'hffff);
        add(REQ_EXTEND, 16'd0, 16'd0);
        add(REQ_COMMIT, 16'd0, 16'd0);
        add(REQ_COMMIT, 16'd0, 16'd0);
        add(REQ_EXTEND, 16'hffff, 16'hffff);
        add(REQ_COMMIT, 16'd0, 16'd0);
        add(REQ_EXTEND, 16'd3200, 16'd3200);
        add(REQ_COMMIT, 16'd0, 16'd0);
        add(REQ_EXTEND, 16'd0, 16'hffff);
        add(REQ_NONE, 16'hffff, 16'hffff);
        add(REQ_COMMIT, 16'd0, 16'd0);
        add(REQ_EXTEND, 16'd3201, 16'd3200);
        add(REQ_COMMIT, 16'd0, 16'd0);
        add(REQ_CLEAR, 16'hffff, 16'd0);
        add(REQ_EXTEND, 16'd3200, 16'd3250);
        add(REQ_COMMIT, 16'd0, 16'd0);
        wait_drained();

        cfg_write(CFG_START_X, 16'hffff);
        cfg_write(CFG_START_Y, 16'd0);
        cfg_write(CFG_GOAL_X, 16'hfff0);
        cfg_write(CFG_GOAL_Y, 16'd16);
        cfg_write(CFG_STEP, 16'd255);
        cfg_write(CFG_REACH, 16'd4095);
        add(REQ_EXTEND, 16'd0, 16'd0);
        add(REQ_CLEAR, 16'd0, 16'd0);
        add(REQ_EXTEND, 16'd0, 16'hffff);
        add(REQ_COMMIT, 16'd0, 16'd0);
        add(REQ_EXTEND, 16'hffff, 16'd0);
        add(REQ_COMMIT, 16'd0, 16'd0);
        add(REQ_EXTEND, 16'hfff8, 16'd2);
        add(REQ_COMMIT, 16'd0, 16'd0);
        wait_drained();

        cfg_write(CFG_START_X, 16'd3200);
        cfg_write(CFG_START_Y, 16'd3200);
        cfg_write(CFG_STEP, 16'd5);
        add(REQ_CLEAR, 16'd0, 16'd0);
        add(REQ_EXTEND, 16'd3300, 16'd3100);
        add(REQ_COMMIT, 16'd0, 16'd0);
        add(REQ_COMMIT, 16'd0, 16'd0);
        add(REQ_CLEAR, 16'd0, 16'd0);
        wait_drained();

        cfg_write(CFG_GOAL_X, 16'd3300);
        cfg_write(CFG_GOAL_Y, 16'd3300);
        cfg_write(CFG_REACH, 16'd40);
        random_phase(RAND_ITEMS / 3, 16'd3200, 16'd3200);
        wait_drained();

        cfg_write(CFG_START_X, 16'd0);
        cfg_write(CFG_START_Y, 16'd0);
        cfg_write(CFG_GOAL_X, 16'd0);
        cfg_write(CFG_GOAL_Y, 16'd0);
        cfg_write(CFG_STEP, 16'd1);
        cfg_write(CFG_REACH, 16'd0);
        add(REQ_CLEAR, 16'd0, 16'd0);
        random_phase(RAND_ITEMS / 3, 16'd0, 16'd0);
        wait_drained();

        cfg_write(CFG_START_X, 16'hff00);
        cfg_write(CFG_START_Y, 16'hff00);
        cfg_write(CFG_GOAL_X, 16'hffff);
        cfg_write(CFG_GOAL_Y, 16'hffff);
        cfg_write(CFG_STEP, 16'd200);
        cfg_write(CFG_REACH, 16'd300);
        add(REQ_CLEAR, 16'd0, 16'd0);
        quiet = 1;
        random_phase(RAND_ITEMS / 3, 16'hff00, 16'hff00);
        wait_drained();

        $display("Run covered %0d result beats, %0d table-full commits, %0d goal hits,",
                 n_results, n_full, n_reached);
        $display("over six register settings with random stalls on both channels.");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/rrtne_pkg.sv
sv/rrtne_ram.sv
sv/rrtne_ctrl.sv
sv/rrtne_dpath.sv
sv/rrt_nearest_extend_engine_top.sv
verif/rrt_nearest_extend_engine_top_tb.sv
